### src/lps_pkg.sv
`default_nettype none
package lps_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int DIM_MIN       = 3;
  localparam int HEIGHT_MAX    = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int CENTER_GAIN   = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 8'd0,
    CFG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_t;

  // line buffer control, top -> lps_lines
  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_col;
    logic             mid_we;
    logic [PIX_W-1:0] mid_wdata;
    logic             up_we;
    logic [POS_W-1:0] up_col;
    logic [PIX_W-1:0] up_wdata;
  } lines_ctl_t;

  // line buffer taps, lps_lines -> top
  typedef struct packed {
    logic [PIX_W-1:0] mid_c;
    logic [PIX_W-1:0] mid_n;
    logic [PIX_W-1:0] up_c;
  } lines_taps_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(DIM_MIN)) begin
      res = DIM_W'(DIM_MIN);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### src/lps_in_if.sv
`default_nettype none
interface lps_in_if;
  logic                      valid;
  logic                      ready;
  logic [lps_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

### src/lps_out_if.sv
`default_nettype none
interface lps_out_if;
  logic                      valid;
  logic                      ready;
  logic [lps_pkg::POS_W-1:0] out_row;
  logic [lps_pkg::POS_W-1:0] out_col;
  logic [lps_pkg::PIX_W-1:0] value;
  logic                      frame_end;

  modport source (output valid, output out_row, output out_col, output value,
                  output frame_end, input ready);
  modport sink   (input valid, input out_row, input out_col, input value,
                  input frame_end, output ready);
endinterface
`default_nettype wire

### src/lps_cfg_if.sv
`default_nettype none
interface lps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lps_pkg::CFG_IDX_W-1:0]  index;
  logic [lps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/lps_lines.sv
`default_nettype none
// Two line buffers: middle (row r-1) and upper (row r-2), registered reads.
module lps_lines #(
  parameter int MAX_WIDTH = lps_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire lps_pkg::lines_ctl_t  ctl,
  output lps_pkg::lines_taps_t      taps
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int POS_W = lps_pkg::POS_W;
  localparam int PIX_W = lps_pkg::PIX_W;

  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];

  logic [POS_W:0]      col_n;
  logic [AW+POS_W-1:0] ext_c;
  logic [AW+POS_W:0]   ext_n;
  logic [AW+POS_W-1:0] ext_u;
  logic [AW-1:0]       a_c;
  logic [AW-1:0]       a_n;
  logic [AW-1:0]       a_u;

  logic [PIX_W-1:0] mid_c_r;
  logic [PIX_W-1:0] mid_n_r;
  logic [PIX_W-1:0] up_c_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_data_r;

  // c+1 runs past the last column (wrapping only at the buffer depth); that tap is unused on the right border
  assign col_n = (POS_W+1)'(ctl.rd_col) + (POS_W+1)'(1);
  assign ext_c = {{AW{1'b0}}, ctl.rd_col};
  assign ext_n = {{AW{1'b0}}, col_n};
  assign ext_u = {{AW{1'b0}}, ctl.up_col};
  assign a_c   = ext_c[AW-1:0];
  assign a_n   = ext_n[AW-1:0];
  assign a_u   = ext_u[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.mid_we) begin
      mid_mem[a_c] <= ctl.mid_wdata;
    end
    if (ctl.rd_en) begin
      mid_c_r <= mid_mem[a_c];
      mid_n_r <= mid_mem[a_n];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.up_we) begin
      up_mem[a_u] <= ctl.up_wdata;
    end
    if (ctl.rd_en) begin
      up_c_r <= up_mem[a_c];
    end
  end

  // an upper write is not yet seen by a read of the same column; bypass when it hits the read column
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd_hit_r  <= ctl.up_we && (ctl.up_col == ctl.rd_col);
      fwd_data_r <= ctl.up_wdata;
    end
  end

  assign taps.mid_c = mid_c_r;
  assign taps.mid_n = mid_n_r;
  assign taps.up_c  = fwd_hit_r ? fwd_data_r : up_c_r;

endmodule
`default_nettype wire

### src/laplacian_sharpen_3x3_core.sv
// Pipeline: an accepted pixel is registered in s1 (line buffer read and kernel), then its
//   results are registered in the s2 output register, which drives the output port.
// Throughput: one pixel per clock while the output is not stalled; on the last row of a frame
//   each pixel yields two results, and s2 frees up for the next pixel only after both have left the single output port.
// Reset (rst_n, synchronous, active low): position counters, pipeline valids and the
//   output stage clear; width/height return to 640/480. Line buffers are not cleared.
`default_nettype none
module laplacian_sharpen_3x3_core #(
  parameter int MAX_WIDTH = lps_pkg::MAX_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lps_in_if.sink    in_if,
  lps_out_if.source out_if,
  lps_cfg_if.sink   cfg_if
);

  localparam int PIX_W = lps_pkg::PIX_W;
  localparam int POS_W = lps_pkg::POS_W;
  localparam int DIM_W = lps_pkg::DIM_W;

  // widest usable row: the smaller of the buffer depth and the 12-bit column range
  localparam int W_HI  = (MAX_WIDTH < lps_pkg::HEIGHT_MAX) ? MAX_WIDTH : lps_pkg::HEIGHT_MAX;
  localparam int W_RST = (lps_pkg::WIDTH_RESET > W_HI) ? W_HI : lps_pkg::WIDTH_RESET;
  localparam logic [DIM_W-1:0] W_HI_V  = DIM_W'(W_HI);
  localparam logic [DIM_W-1:0] H_HI_V  = DIM_W'(lps_pkg::HEIGHT_MAX);

  // ---------------------------------------------------------------------------
  // Configuration: values are clamped on write, so the datapath sees legal
  // dimensions only.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] width_m1;
  logic [DIM_W-1:0] height_m1;
  logic             cfg_xfer;

  assign cfg_if.ready = 1'b1;
  assign cfg_xfer     = cfg_if.valid && cfg_if.ready;
  assign width_m1     = width_r - DIM_W'(1);
  assign height_m1    = height_r - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(W_RST);
      height_r <= DIM_W'(lps_pkg::HEIGHT_RESET);
    end else if (cfg_xfer) begin
      case (cfg_if.index)
        lps_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= lps_pkg::clamp_dim(cfg_if.data, W_HI_V);
        end
        lps_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= lps_pkg::clamp_dim(cfg_if.data, H_HI_V);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake plumbing.
  //   s1: window fetch / kernel stage (line buffer read data arrives here)
  //   s2: output register, holds one or two results for the current pixel
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic out_xfer;
  logic s1_adv;
  logic s2_last;
  logic s2_free;

  logic             s1_v_r;
  logic [POS_W-1:0] s1_row_r;
  logic [POS_W-1:0] s1_col_r;
  logic [PIX_W-1:0] s1_px_r;

  logic             s2_v_r;
  logic             s2_two_r;
  logic             s2_ph_r;
  logic [POS_W-1:0] s2_row_r;
  logic [POS_W-1:0] s2_rowb_r;
  logic [POS_W-1:0] s2_col_r;
  logic [PIX_W-1:0] s2_val_r;
  logic             s2_fe_r;

  assign s2_last     = !s2_two_r || s2_ph_r;
  assign out_xfer    = out_if.valid && out_if.ready;
  assign s2_free     = !s2_v_r || (out_if.ready && s2_last);
  assign s1_adv      = s1_v_r && s2_free;
  assign in_if.ready = !s1_v_r || s2_free;
  assign in_xfer     = in_if.valid && in_if.ready;

  // ---------------------------------------------------------------------------
  // Position tracking: a frame start or a dimension change that leaves the
  // counters out of range is folded in before the pixel is placed.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] row_cnt_r;
  logic [POS_W-1:0] col_cnt_r;
  logic [POS_W-1:0] row_cnt_nxt;
  logic [POS_W-1:0] col_cnt_nxt;
  logic [POS_W-1:0] pos_row;
  logic [POS_W-1:0] pos_col;

  always_comb begin
    logic [DIM_W-1:0] rc;
    logic [DIM_W-1:0] cc;
    logic [DIM_W-1:0] rn;
    logic [DIM_W-1:0] cn;
    rc = in_if.frame_start ? '0 : DIM_W'(row_cnt_r);
    cc = in_if.frame_start ? '0 : DIM_W'(col_cnt_r);
    if (cc >= width_r) begin
      cc = '0;
      rc = rc + DIM_W'(1);
    end
    if (rc >= height_r) begin
      rc = '0;
    end
    cn = cc + DIM_W'(1);
    rn = rc;
    if (cn >= width_r) begin
      cn = '0;
      rn = rc + DIM_W'(1);
      if (rn >= height_r) begin
        rn = '0;
      end
    end
    pos_row     = rc[POS_W-1:0];
    pos_col     = cc[POS_W-1:0];
    row_cnt_nxt = rn[POS_W-1:0];
    col_cnt_nxt = cn[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_xfer) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers. Middle line is read at c and c+1 and takes the new pixel on
  // the accept edge; upper line takes the old middle value once it is read.
  // ---------------------------------------------------------------------------
  lps_pkg::lines_ctl_t  lines_ctl;
  lps_pkg::lines_taps_t taps;
  logic [PIX_W-1:0]     left_mid_r;

  always_comb begin
    lines_ctl.rd_en     = in_xfer;
    lines_ctl.rd_col    = pos_col;
    lines_ctl.mid_we    = in_xfer;
    lines_ctl.mid_wdata = in_if.pixel;
    lines_ctl.up_we     = s1_adv;
    lines_ctl.up_col    = s1_col_r;
    lines_ctl.up_wdata  = taps.mid_c;
  end

  lps_lines #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .ctl  (lines_ctl),
    .taps (taps)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_row_r <= pos_row;
      s1_col_r <= pos_col;
      s1_px_r  <= in_if.pixel;
    end
  end

  // left neighbor on the middle row is simply the previous pixel's middle tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_mid_r <= '0;
    end else if (s1_adv) begin
      left_mid_r <= taps.mid_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Kernel: 5*center - left - right - up - down, clamped to 0..255.
  // Result A is the row above the incoming pixel (row 0 emits zeros at once);
  // result B is the zero bottom border, only on the last row.
  // ---------------------------------------------------------------------------
  logic [10:0]       mid_x5;
  logic signed [12:0] acc;
  logic [PIX_W-1:0]  filt;
  logic              interior;
  logic              row_zero;
  logic              right_edge;
  logic              two_res;
  logic [POS_W-1:0]  a_row;

  assign mid_x5 = 11'(taps.mid_c) * 11'(lps_pkg::CENTER_GAIN);
  assign acc    = $signed({2'b00, mid_x5})
                - $signed({5'b00000, left_mid_r})
                - $signed({5'b00000, taps.mid_n})
                - $signed({5'b00000, taps.up_c})
                - $signed({5'b00000, s1_px_r});

  always_comb begin
    if (acc < 13'sd0) begin
      filt = '0;
    end else if (acc > 13'sd255) begin
      filt = '1;
    end else begin
      filt = acc[PIX_W-1:0];
    end
  end

  assign row_zero   = (s1_row_r == '0);
  assign right_edge = ({1'b0, s1_col_r} == width_m1);
  assign interior   = !row_zero && (s1_row_r != POS_W'(1))
                      && (s1_col_r != '0) && !right_edge;
  assign two_res    = !row_zero && ({1'b0, s1_row_r} == height_m1);
  assign a_row      = row_zero ? '0 : (s1_row_r - POS_W'(1));

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s2_ph_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r  <= 1'b1;
      s2_ph_r <= 1'b0;
    end else if (out_xfer) begin
      if (s2_last) begin
        s2_v_r <= 1'b0;
      end else begin
        s2_ph_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_two_r  <= two_res;
      s2_row_r  <= a_row;
      s2_rowb_r <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_val_r  <= interior ? filt : '0;
      s2_fe_r   <= right_edge;
    end
  end

  assign out_if.valid     = s2_v_r;
  assign out_if.out_row   = s2_ph_r ? s2_rowb_r : s2_row_r;
  assign out_if.out_col   = s2_col_r;
  assign out_if.value     = s2_ph_r ? '0 : s2_val_r;
  assign out_if.frame_end = s2_ph_r && s2_fe_r;

`ifndef SYNTHESIS
  // end of frame only on the bottom-right pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_end |->
      ({1'b0, out_if.out_row} == height_m1) && ({1'b0, out_if.out_col} == width_m1))
    else $error("frame_end away from the last pixel");

  // borders always come out as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.value != '0) |->
      (out_if.out_row != '0) && (out_if.out_col != '0)
      && ({1'b0, out_if.out_col} != width_m1)
      && ({1'b0, out_if.out_row} != height_m1))
    else $error("nonzero value on a border pixel");

  // second result phase only exists for a two-result pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_ph_r |-> s2_two_r)
    else $error("second result phase without a second result");

  // a held result stays put while the sink stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> $stable(out_if.out_col) && $stable(out_if.value))
    else $error("output changed under back-pressure");
`endif

endmodule
`default_nettype wire

### tb/lps_sharpen_checker.sv
`timescale 1ns / 1ps
module lps_sharpen_checker #(
  parameter int MAX_WIDTH = lps_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lps_in_if    in_mon,
  lps_out_if   out_mon,
  lps_cfg_if   cfg_mon,
  output int   fail_count,
  output int   wait_count
);
  import lps_pkg::*;

  localparam int unsigned POS_SPAN  = 1 << POS_W;
  localparam int unsigned WIDTH_CAP = (MAX_WIDTH < POS_SPAN) ? MAX_WIDTH : POS_SPAN;
  localparam int          PIX_MAX   = (1 << PIX_W) - 1;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic             frame_end;
  } sharp_px_t;

  // shadow copies of the two line stores, rows r-2 and r-1
  logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [PIX_W-1:0] left_mid;
  sharp_px_t        sharp_q [$];
  int               n_bad  = 0;
  int               n_wait = 0;

  assign fail_count = n_bad;
  assign wait_count = n_wait;

  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] raw,
                                          input int unsigned hi);
    if (raw < DIM_MIN) return DIM_MIN;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic sharp_px_t mk_px(input int unsigned r, input int unsigned c,
                                      input int v, input logic fe);
    sharp_px_t px;
    px.row       = POS_W'(r);
    px.col       = POS_W'(c);
    px.value     = PIX_W'(v);
    px.frame_end = fe;
    return px;
  endfunction

  always @(posedge clk) begin : track
    sharp_px_t        got;
    sharp_px_t        want;
    int unsigned      w_eff;
    int unsigned      h_eff;
    int unsigned      r;
    int unsigned      c;
    int               acc;
    logic [PIX_W-1:0] mid_c;
    if (!rst_n) begin
      width_reg  = DIM_W'(WIDTH_RESET);
      height_reg = DIM_W'(HEIGHT_RESET);
      row_pos    = 0;
      col_pos    = 0;
      left_mid   = '0;
      sharp_q.delete();
    end else begin
      // compare before predicting, so a stray result never pairs with a new pixel
      if (out_mon.valid && out_mon.ready) begin
        got.row       = out_mon.out_row;
        got.col       = out_mon.out_col;
        got.value     = out_mon.value;
        got.frame_end = out_mon.frame_end;
        if (sharp_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("%0t: unexpected result row %0d col %0d value %0d frame_end %0b",
                     $realtime, got.row, got.col, got.value, got.frame_end);
        end else begin
          want = sharp_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.value !== want.value || got.frame_end !== want.frame_end) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
              $display({"%0t: result mismatch, expected row %0d col %0d value %0d ",
                        "frame_end %0b, got row %0d col %0d value %0d frame_end %0b"},
                       $realtime, want.row, want.col, want.value, want.frame_end,
                       got.row, got.col, got.value, got.frame_end);
          end
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_mon.data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_mon.data;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        w_eff = fit_dim(width_reg, WIDTH_CAP);
        h_eff = fit_dim(height_reg, HEIGHT_MAX);
        if (in_mon.frame_start) begin
          row_pos = 0;
          col_pos = 0;
        end
        // dimensions may have shrunk under the counters
        if (col_pos >= w_eff) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= h_eff) row_pos = 0;
        r     = row_pos;
        c     = col_pos;
        mid_c = middle_row[c];

        if (r == 0) begin
          sharp_q.insert(sharp_q.size(), mk_px(0, c, 0, 1'b0));
        end else begin
          acc = 0;
          if (r != 1 && c != 0 && c != w_eff - 1) begin
            acc = CENTER_GAIN * int'(mid_c) - int'(left_mid) - int'(middle_row[c + 1])
                  - int'(upper_row[c]) - int'(in_mon.pixel);
            if (acc < 0) acc = 0;
            else if (acc > PIX_MAX) acc = PIX_MAX;
          end
          sharp_q.insert(sharp_q.size(), mk_px(r - 1, c, acc, 1'b0));
          if (r == h_eff - 1)
            sharp_q.insert(sharp_q.size(), mk_px(r, c, 0, c == w_eff - 1));
        end

        left_mid      = mid_c;
        upper_row[c]  = mid_c;
        middle_row[c] = in_mon.pixel;
        col_pos       = c + 1;
        if (col_pos >= w_eff) begin
          col_pos = 0;
          row_pos = r + 1;
          if (row_pos >= h_eff) row_pos = 0;
        end
      end
    end
    n_wait = sharp_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lps_pkg::*;

  // handshake pressure profiles, cycled through phase by phase
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int HEAVY_PCT      = 55;
  localparam int LIGHT_PCT      = 8;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIM_ALL_ONES   = 8191;  // every data bit set, clamps to the top size
  localparam int WIDE_MAX       = 40;    // widest random frame
  localparam int TALL_ROWS      = 40;    // rows sent into the clamped-height frame
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd7;

  // 3x3 frames: lone bright center (clamps high), dark center in a bright
  // field (clamps low), and a plain in-range case
  localparam logic [PIX_W-1:0] DIRECTED_PIX [3][9] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd10,  8'd20,  8'd30,  8'd40,  8'd60,  8'd50,  8'd70,  8'd80,  8'd90}
  };

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic sink_ready = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles   = 0;
  int   fail_count;
  int   wait_count;

  lps_in_if  pix_ch ();
  lps_out_if sharp_ch ();
  lps_cfg_if cfg_ch ();

  assign sharp_ch.ready = sink_ready;

  laplacian_sharpen_3x3_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_ch),
    .out_if (sharp_ch),
    .cfg_if (cfg_ch)
  );

  // watches all three channels, predicts and scores the results
  lps_sharpen_checker #(
    .MAX_WIDTH (MAX_WIDTH_DEF)
  ) sharpen_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (pix_ch),
    .out_mon    (sharp_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .wait_count (wait_count)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // result side back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    sink_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: too long without any transfer on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((pix_ch.valid && pix_ch.ready) || (sharp_ch.valid && sharp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("laplacian_sharpen_3x3_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? HEAVY_PCT : (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? HEAVY_PCT : (mode == IDLE_BOTH) ? LIGHT_PCT : 0;
  endtask

  // biased toward the extremes so both clamps fire often
  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 35) return PIX_W'($urandom_range(15));
    return PIX_W'($urandom_range(255));
  endfunction

  // one pixel transfer; valid stays high across back-to-back pixels
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      pix_ch.pixel <= PIX_W'($urandom_range(255));
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic stream_pixels(input int unsigned count, input bit lead_start,
                               input int stray_pct);
    for (int unsigned i = 0; i < count; i++)
      push_pixel(rand_pixel(), (i == 0 && lead_start) || ($urandom_range(99) < stray_pct));
  endtask

  // register writes only once the block has drained every pending result
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (wait_count != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned w_use;
    int unsigned h_use;
    int unsigned w_put;
    int unsigned h_put;
    int unsigned total;
    int unsigned count;
    int unsigned frames;
    int          phase;
    int          sent_random;
    bit          lead;

    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_IMAGE_WIDTH;
    cfg_ch.data        = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: smallest frame, out-of-range sizes, clamp extremes ---
    set_idling(IDLE_NONE);
    write_reg(CFG_IMAGE_WIDTH, DIM_MIN - 1);   // below range, used as 3
    write_reg(CFG_IMAGE_HEIGHT, 0);            // all zeros, used as 3
    for (int i = 0; i < 9; i++) push_pixel(DIRECTED_PIX[0][i], i == 0);
    // no start mark: counters already wrapped to 0,0 at frame end
    for (int i = 0; i < 9; i++) push_pixel(DIRECTED_PIX[1][i], 1'b0);
    // write to an unmapped index must leave both sizes alone
    write_reg(CFG_UNMAPPED, 'h1555);
    write_reg(CFG_IMAGE_WIDTH, DIM_MIN);
    write_reg(CFG_IMAGE_HEIGHT, DIM_MIN);
    for (int i = 0; i < 9; i++) push_pixel(DIRECTED_PIX[2][i], i == 0);

    // --- wide fill frame: writes every line store column the random sizes
    // reach, so later mid-frame size changes never read an unwritten location ---
    set_idling(IDLE_BOTH);
    write_reg(CFG_IMAGE_WIDTH, WIDE_MAX);
    write_reg(CFG_IMAGE_HEIGHT, DIM_MIN);
    stream_pixels(WIDE_MAX * DIM_MIN, 1'b1, 0);

    // --- height with every bit set (clamps to the top size), frame cut short ---
    set_idling(IDLE_NONE);
    write_reg(CFG_IMAGE_WIDTH, DIM_MIN);
    write_reg(CFG_IMAGE_HEIGHT, DIM_ALL_ONES);
    stream_pixels(DIM_MIN * TALL_ROWS, 1'b1, 0);

    // --- random phases: mostly whole frames with random content; some
    // frames cut short, some restarted mid-way, some continued across a
    // size change (counters past the new size) ---
    phase       = 0;
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'(phase % 4));
      phase++;
      w_use = ($urandom_range(9) == 0) ? $urandom_range(WIDE_MAX, 13)
                                       : $urandom_range(12, DIM_MIN);
      h_use = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, DIM_MIN);
      w_put = (w_use == DIM_MIN && $urandom_range(1)) ? $urandom_range(DIM_MIN - 1) : w_use;
      h_put = (h_use == DIM_MIN && $urandom_range(1)) ? $urandom_range(DIM_MIN - 1) : h_use;
      if ($urandom_range(1)) begin
        write_reg(CFG_IMAGE_WIDTH, w_put);
        write_reg(CFG_IMAGE_HEIGHT, h_put);
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, h_put);
        write_reg(CFG_IMAGE_WIDTH, w_put);
      end
      frames = $urandom_range(3, 1);
      for (int unsigned f = 0; f < frames; f++) begin
        total = w_use * h_use;
        count = (f == frames - 1 && $urandom_range(4) == 0) ? $urandom_range(total - 1, 1)
                                                            : total;
        lead  = ($urandom_range(3) != 0);
        stream_pixels(count, lead, ($urandom_range(9) == 0) ? 3 : 0);
        sent_random += count;
      end
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (wait_count != 0) @(negedge clk);
    // wait out the drain period to catch any extra result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("laplacian_sharpen_3x3_core test passed");
    end else begin
      $display("laplacian_sharpen_3x3_core test failed");
    end
    $finish;
  end

endmodule
